[src/qpc_pkg.sv]
// ----------------------------------------------------------------------------
// qpc_pkg: shared types and constants
// Widths of the quaternion/vector datapath and the sideband carried along it.
// ----------------------------------------------------------------------------
package qpc_pkg;

   localparam int IN_W  = 32;   // quaternion and vector input width
   localparam int P_W   = 31;   // block-scaled quaternion part, signed, |p| < 2^30
   localparam int PR_W  = 2 * P_W;
   localparam int N_W   = 64;   // numerator and accumulator width
   localparam int FRAC  = 29;   // fraction bits of the matrix entries
   localparam int D_W   = 33;   // divisor width, s >> FRAC
   localparam int QB    = 31;   // quotient magnitude bits
   localparam int R_W   = 32;   // signed matrix entry width
   localparam int SH_W  = 5;    // left shift amount width
   localparam int OUT_W = 32;

   // Fields that ride alongside the arithmetic from entry to exit.
   typedef struct packed {
      logic                    opcode;
      logic                    bad;
      logic signed [IN_W-1:0]  vec_x;
      logic signed [IN_W-1:0]  vec_y;
      logic signed [IN_W-1:0]  vec_z;
   } side_type;

endpackage

[src/quat_pose_center_translation_core.sv]
// ----------------------------------------------------------------------------
// quat_pose_center_translation_core: pose center / translation converter
// Rotates a Q16.16 vector by the normalized rotation of a raw Q4.27 WXYZ
// quaternion and negates it: t = -R*C, or C = -R^T*t.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   --------  -----------------  ---------------------------------------------
//   request   start / busy       req_opcode, req_quat_w..z, req_vec_x..z
//   response  rsp_valid strobe   rsp_out_x..z, rsp_bad_quaternion, rsp_saturated
//
// A request transfer happens on every clock edge where start is high and busy
// is low; busy is only high during reset, so one pose enters per cycle.
// Each pose passes in order through block scaling, numerators and norm, the
// nine-lane restoring divider (one quotient bit per stage over 31 bits, plus
// entry and exit registers), and matrix product, sum and rounding.
// The response is a one-cycle strobe that the receiver cannot hold off, so the
// pipeline never stalls. Reset clears all valid bits synchronously; the data
// registers are not reset.
// A quaternion whose four parts are all zero gives a zero vector with
// rsp_bad_quaternion set and rsp_saturated clear.
// ----------------------------------------------------------------------------
module quat_pose_center_translation_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_quat_w,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_quat_x,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_quat_y,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_quat_z,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_vec_x,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_vec_y,
   input  logic signed [qpc_pkg::IN_W-1:0]    req_vec_z,
   output logic                               rsp_valid,
   output logic signed [qpc_pkg::OUT_W-1:0]   rsp_out_x,
   output logic signed [qpc_pkg::OUT_W-1:0]   rsp_out_y,
   output logic signed [qpc_pkg::OUT_W-1:0]   rsp_out_z,
   output logic                               rsp_bad_quaternion,
   output logic                               rsp_saturated
);
   import qpc_pkg::*;

   logic                  in_vld;
   side_type              in_side;
   logic [IN_W-1:0]       quat [4];

   logic                  sc_vld;
   side_type              sc_side;
   logic signed [P_W-1:0] sc_p [4];

   logic                  mx_vld;
   side_type              mx_side;
   logic signed [N_W-1:0] mx_num [9];
   logic [D_W-1:0]        mx_d;

   logic                  dv_vld;
   side_type              dv_side;
   logic signed [R_W-1:0] dv_r [9];

   logic signed [OUT_W-1:0] res [3];

   // Nothing can back up, so the block only refuses transfers during reset.
   assign busy   = reset;
   assign in_vld = start & ~busy;

   always_comb begin
      in_side.opcode = req_opcode;
      in_side.bad    = 1'b0;    // decided in the scaling stage
      in_side.vec_x  = req_vec_x;
      in_side.vec_y  = req_vec_y;
      in_side.vec_z  = req_vec_z;
      quat[0] = req_quat_w;
      quat[1] = req_quat_x;
      quat[2] = req_quat_y;
      quat[3] = req_quat_z;
   end

   qpc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (in_vld),
      .side_in   (in_side),
      .q_in      (quat),
      .valid_out (sc_vld),
      .side_out  (sc_side),
      .p_out     (sc_p)
   );

   qpc_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sc_vld),
      .side_in   (sc_side),
      .p_in      (sc_p),
      .valid_out (mx_vld),
      .side_out  (mx_side),
      .num_out   (mx_num),
      .d_out     (mx_d)
   );

   qpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (mx_vld),
      .side_in   (mx_side),
      .num_in    (mx_num),
      .d_in      (mx_d),
      .valid_out (dv_vld),
      .side_out  (dv_side),
      .r_out     (dv_r)
   );

   qpc_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (dv_vld),
      .side_in   (dv_side),
      .r_in      (dv_r),
      .valid_out (rsp_valid),
      .res_out   (res),
      .bad_out   (rsp_bad_quaternion),
      .sat_out   (rsp_saturated)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];

endmodule

[src/qpc_scale.sv]
// ----------------------------------------------------------------------------
// qpc_scale: quaternion block scaling
// Two stages that shift all four parts by a common amount so the largest
// magnitude lands in [2^29, 2^30).
// ----------------------------------------------------------------------------
module qpc_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  qpc_pkg::side_type                  side_in,
   input  logic [qpc_pkg::IN_W-1:0]           q_in [4],
   output logic                               valid_out,
   output qpc_pkg::side_type                  side_out,
   output logic signed [qpc_pkg::P_W-1:0]     p_out [4]
);
   import qpc_pkg::*;

   logic [IN_W-1:0] mag_in [4];
   logic [3:0]      neg_in;
   logic [IN_W-1:0] orv;
   logic [SH_W-1:0] msb;
   logic [SH_W-1:0] ls_in;
   logic [1:0]      rs_in;
   side_type        sa_side_in;

   logic            sa_vld_ff;
   side_type        sa_side_ff;
   logic [IN_W-1:0] mag_ff [4];
   logic [3:0]      neg_ff;
   logic [SH_W-1:0] ls_ff;
   logic [1:0]      rs_ff;

   logic signed [P_W-1:0] p_in [4];
   logic                  vld_ff;
   side_type              side_ff;
   logic signed [P_W-1:0] p_ff [4];

   // The common shift follows from the OR of the magnitudes: its top set bit
   // is the top set bit of the largest part.
   always_comb begin
      orv = '0;
      for (int i = 0; i < 4; i++) begin
         neg_in[i] = q_in[i][IN_W-1];
         mag_in[i] = neg_in[i] ? IN_W'(-q_in[i]) : q_in[i];
         orv       = orv | mag_in[i];
      end
      msb = '0;
      for (int b = 0; b <= FRAC; b++) begin
         if (orv[b]) begin
            msb = SH_W'(b);
         end
      end
      if (orv[IN_W-1]) begin
         rs_in = 2'd2;
         ls_in = '0;
      end else if (orv[IN_W-2]) begin
         rs_in = 2'd1;
         ls_in = '0;
      end else begin
         rs_in = 2'd0;
         ls_in = SH_W'(FRAC) - msb;
      end
      sa_side_in     = side_in;
      sa_side_in.bad = (orv == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= valid_in;
      end
      sa_side_ff <= sa_side_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      ls_ff      <= ls_in;
      rs_ff      <= rs_in;
   end

   always_comb begin
      logic [2*IN_W-1:0] wide;
      for (int i = 0; i < 4; i++) begin
         wide    = ((2*IN_W)'(mag_ff[i]) << ls_ff) >> rs_ff;
         p_in[i] = neg_ff[i] ? -$signed({1'b0, wide[P_W-2:0]})
                             :  $signed({1'b0, wide[P_W-2:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= sa_vld_ff;
      end
      side_ff <= sa_side_ff;
      p_ff    <= p_in;
   end

   assign valid_out = vld_ff;
   assign side_out  = side_ff;
   assign p_out     = p_ff;

endmodule

[src/qpc_matrix.sv]
// ----------------------------------------------------------------------------
// qpc_matrix: rotation numerators and norm
// One stage of part products, one stage of the nine numerators, the squared
// norm and the divisor s >> 29.
// ----------------------------------------------------------------------------
module qpc_matrix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  qpc_pkg::side_type                  side_in,
   input  logic signed [qpc_pkg::P_W-1:0]     p_in [4],
   output logic                               valid_out,
   output qpc_pkg::side_type                  side_out,
   output logic signed [qpc_pkg::N_W-1:0]     num_out [9],
   output logic [qpc_pkg::D_W-1:0]            d_out
);
   import qpc_pkg::*;

   localparam int WW = 0, XX = 1, YY = 2, ZZ = 3, XY = 4;
   localparam int WZ = 5, XZ = 6, WY = 7, YZ = 8, WX = 9;
   localparam int PW = 0, PX = 1, PY = 2, PZ = 3;

   logic                   pr_vld_ff;
   side_type               pr_side_ff;
   logic signed [PR_W-1:0] prd_ff [10];
   logic signed [PR_W-1:0] prd_in [10];

   logic signed [N_W-1:0]  e [10];
   logic signed [N_W-1:0]  s_in;
   logic signed [N_W-1:0]  num_in [9];

   logic                   vld_ff;
   side_type               side_ff;
   logic signed [N_W-1:0]  num_ff [9];
   logic [D_W-1:0]         d_ff;

   always_comb begin
      prd_in[WW] = p_in[PW] * p_in[PW];
      prd_in[XX] = p_in[PX] * p_in[PX];
      prd_in[YY] = p_in[PY] * p_in[PY];
      prd_in[ZZ] = p_in[PZ] * p_in[PZ];
      prd_in[XY] = p_in[PX] * p_in[PY];
      prd_in[WZ] = p_in[PW] * p_in[PZ];
      prd_in[XZ] = p_in[PX] * p_in[PZ];
      prd_in[WY] = p_in[PW] * p_in[PY];
      prd_in[YZ] = p_in[PY] * p_in[PZ];
      prd_in[WX] = p_in[PW] * p_in[PX];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else begin
         pr_vld_ff <= valid_in;
      end
      pr_side_ff <= side_in;
      prd_ff     <= prd_in;
   end

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         e[i] = N_W'(prd_ff[i]);
      end
      s_in       = e[WW] + e[XX] + e[YY] + e[ZZ];
      num_in[0]  = e[WW] + e[XX] - e[YY] - e[ZZ];
      num_in[1]  = (e[XY] - e[WZ]) <<< 1;
      num_in[2]  = (e[XZ] + e[WY]) <<< 1;
      num_in[3]  = (e[XY] + e[WZ]) <<< 1;
      num_in[4]  = e[WW] - e[XX] + e[YY] - e[ZZ];
      num_in[5]  = (e[YZ] - e[WX]) <<< 1;
      num_in[6]  = (e[XZ] - e[WY]) <<< 1;
      num_in[7]  = (e[YZ] + e[WX]) <<< 1;
      num_in[8]  = e[WW] - e[XX] - e[YY] + e[ZZ];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= pr_vld_ff;
      end
      side_ff <= pr_side_ff;
      num_ff  <= num_in;
      d_ff    <= s_in[FRAC+D_W-1:FRAC];
   end

   assign valid_out = vld_ff;
   assign side_out  = side_ff;
   assign num_out   = num_ff;
   assign d_out     = d_ff;

endmodule

[src/qpc_div.sv]
// ----------------------------------------------------------------------------
// qpc_div: pipelined restoring divider, nine lanes
// Divides each numerator by the shared divisor, one quotient bit per stage,
// truncating toward zero.
// ----------------------------------------------------------------------------
module qpc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  qpc_pkg::side_type                  side_in,
   input  logic signed [qpc_pkg::N_W-1:0]     num_in [9],
   input  logic [qpc_pkg::D_W-1:0]            d_in,
   output logic                               valid_out,
   output qpc_pkg::side_type                  side_out,
   output logic signed [qpc_pkg::R_W-1:0]     r_out [9]
);
   import qpc_pkg::*;

   logic           vld_ff  [QB+1];
   side_type       side_ff [QB+1];
   logic [D_W-1:0] d_ff    [QB+1];
   logic [N_W-1:0] rem_ff  [QB+1][9];
   logic [QB-1:0]  quo_ff  [QB+1][9];
   logic [8:0]     neg_ff  [QB+1];

   logic                  o_vld_ff;
   side_type              o_side_ff;
   logic signed [R_W-1:0] r_ff [9];

   // Entry: split each numerator into sign and magnitude.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= valid_in;
      end
      side_ff[0] <= side_in;
      d_ff[0]    <= d_in;
      for (int l = 0; l < 9; l++) begin
         neg_ff[0][l] <= num_in[l][N_W-1];
         rem_ff[0][l] <= num_in[l][N_W-1] ? N_W'(-num_in[l]) : N_W'(num_in[l]);
         quo_ff[0][l] <= '0;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_stage
      localparam int BIT = QB - 1 - j;
      logic [N_W-1:0] trial;
      logic [N_W-1:0] rem_in [9];
      logic [QB-1:0]  quo_in [9];

      always_comb begin
         trial = N_W'(d_ff[j]) << BIT;
         for (int l = 0; l < 9; l++) begin
            if (rem_ff[j][l] >= trial) begin
               rem_in[l] = rem_ff[j][l] - trial;
               quo_in[l] = {quo_ff[j][l][QB-2:0], 1'b1};
            end else begin
               rem_in[l] = rem_ff[j][l];
               quo_in[l] = {quo_ff[j][l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
         side_ff[j+1] <= side_ff[j];
         d_ff[j+1]    <= d_ff[j];
         neg_ff[j+1]  <= neg_ff[j];
         rem_ff[j+1]  <= rem_in;
         quo_ff[j+1]  <= quo_in;
      end
   end

   // Exit: put the sign back on each quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= vld_ff[QB];
      end
      o_side_ff <= side_ff[QB];
      for (int l = 0; l < 9; l++) begin
         r_ff[l] <= neg_ff[QB][l] ? -$signed({1'b0, quo_ff[QB][l]})
                                  :  $signed({1'b0, quo_ff[QB][l]});
      end
   end

   assign valid_out = o_vld_ff;
   assign side_out  = o_side_ff;
   assign r_out     = r_ff;

endmodule

[src/qpc_apply.sv]
// ----------------------------------------------------------------------------
// qpc_apply: matrix-vector product, rounding and saturation
// Multiplies R or its transpose by the vector, sums, rounds to Q16.16,
// negates and clips.
// ----------------------------------------------------------------------------
module qpc_apply (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  qpc_pkg::side_type                  side_in,
   input  logic signed [qpc_pkg::R_W-1:0]     r_in [9],
   output logic                               valid_out,
   output logic signed [qpc_pkg::OUT_W-1:0]   res_out [3],
   output logic                               bad_out,
   output logic                               sat_out
);
   import qpc_pkg::*;

   localparam int RND_W = N_W - FRAC + 1;

   logic signed [IN_W-1:0] v [3];
   logic signed [N_W-1:0]  prod_in [3][3];

   logic                   m_vld_ff;
   side_type               m_side_ff;
   logic signed [N_W-1:0]  prod_ff [3][3];

   logic signed [N_W-1:0]  acc_in [3];
   logic                   a_vld_ff;
   side_type               a_side_ff;
   logic signed [N_W-1:0]  acc_ff [3];

   logic signed [OUT_W-1:0] res_in [3];
   logic                    sat_in;
   logic                    vld_ff;
   logic signed [OUT_W-1:0] res_ff [3];
   logic                    bad_ff;
   logic                    sat_ff;

   always_comb begin
      v[0] = side_in.vec_x;
      v[1] = side_in.vec_y;
      v[2] = side_in.vec_z;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (side_in.opcode) begin
               prod_in[i][k] = N_W'(r_in[k*3+i]) * N_W'(v[k]);
            end else begin
               prod_in[i][k] = N_W'(r_in[i*3+k]) * N_W'(v[k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= valid_in;
      end
      m_side_ff <= side_in;
      prod_ff   <= prod_in;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= m_vld_ff;
      end
      a_side_ff <= m_side_ff;
      acc_ff    <= acc_in;
   end

   // Round half away from zero on the magnitude, then negate the signed
   // result and clip it to 32 bits.
   always_comb begin
      logic [N_W-1:0]          mag;
      logic [N_W-1:0]          rnd;
      logic signed [RND_W-1:0] sv;
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag = acc_ff[i][N_W-1] ? N_W'(-acc_ff[i]) : N_W'(acc_ff[i]);
         rnd = (mag + (N_W'(1) << (FRAC-1))) >> FRAC;
         // negation of the product: a positive sum gives a negative result
         sv  = acc_ff[i][N_W-1] ? $signed(RND_W'(rnd)) : -$signed(RND_W'(rnd));
         if (sv[RND_W-1:OUT_W-1] == '0 || sv[RND_W-1:OUT_W-1] == '1) begin
            res_in[i] = sv[OUT_W-1:0];
         end else if (sv[RND_W-1]) begin
            res_in[i] = {1'b1, {(OUT_W-1){1'b0}}};
            sat_in    = 1'b1;
         end else begin
            res_in[i] = {1'b0, {(OUT_W-1){1'b1}}};
            sat_in    = 1'b1;
         end
         if (a_side_ff.bad) begin
            res_in[i] = '0;
         end
      end
      if (a_side_ff.bad) begin
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= a_vld_ff;
      end
      res_ff <= res_in;
      bad_ff <= a_side_ff.bad;
      sat_ff <= sat_in;
   end

   assign valid_out = vld_ff;
   assign res_out   = res_ff;
   assign bad_out   = bad_ff;
   assign sat_out   = sat_ff;

endmodule
